// ===== rtl/sas_pkg.sv =====
package sas_pkg;

	// Operation codes carried on the operation field
	typedef enum logic [3:0] {
		OP_TICK   = 4'd0,
		OP_START  = 4'd1,
		OP_STOP   = 4'd2,
		OP_PAUSE  = 4'd3,
		OP_NEXT   = 4'd4,
		OP_PREV   = 4'd5,
		OP_GOTO   = 4'd6,
		OP_APPEND = 4'd7,
		OP_SET    = 4'd8,
		OP_CLEAR  = 4'd9
	} op_t;

	// One song entry as kept in the table (25 bits)
	typedef struct packed {
		logic [7:0] pattern;
		logic [7:0] bars;
		logic [7:0] reps;
		logic       record;
	} entry_t;

	// One accepted operation
	typedef struct packed {
		logic [3:0] operation;
		logic [5:0] target_index;
		logic [7:0] pattern_number;
		logic [7:0] bar_count;
		logic [7:0] repeat_count;
		logic       record_flag;
	} item_t;

	// One result transaction
	typedef struct packed {
		logic       status;
		logic       play_valid;
		logic [7:0] play_pattern;
		logic [7:0] play_bars;
		logic       play_record;
		logic [5:0] new_entry_index;
		logic [5:0] current_position;
		logic [6:0] entries_in_use;
		logic       is_playing;
	} result_t;

	localparam logic STATUS_DONE    = 1'b0;
	localparam logic STATUS_IGNORED = 1'b1;

endpackage

// ===== rtl/song_arranger_sequencer.sv =====
// Channel  Handshake              Payload
// -------  ---------------------  ------------------------------------------------
// in       in_valid / in_ready    operation, target_index, pattern_number,
//                                 bar_count, repeat_count, record_flag
// out      out_valid / out_ready  status, play_valid, play_pattern, play_bars,
//                                 play_record, new_entry_index, current_position,
//                                 entries_in_use, is_playing
//
// One transaction per cycle while the output is not stalled; each taken input passes
// through the input register, then the result register.
// The song table is read every cycle at the upcoming position, so its registered
// output is already valid when the next operation sits in the input register.
// Reset clears count, position, repeat counter and flags; the table is not cleared.
// A stalled output holds its result and back-pressures the input register only.
module song_arranger_sequencer #(
	parameter int MAX_ENTRIES = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [3:0] operation,
	input  logic [5:0] target_index,
	input  logic [7:0] pattern_number,
	input  logic [7:0] bar_count,
	input  logic [7:0] repeat_count,
	input  logic       record_flag,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       status,
	output logic       play_valid,
	output logic [7:0] play_pattern,
	output logic [7:0] play_bars,
	output logic       play_record,
	output logic [5:0] new_entry_index,
	output logic [5:0] current_position,
	output logic [6:0] entries_in_use,
	output logic       is_playing
);
	import sas_pkg::*;

	localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

	logic             valid_s1, valid_s2;
	item_t            item_s1;
	result_t          res_s2, res_comb;
	logic             fire;
	logic [IDX_W-1:0] pos_d, wr_addr;
	logic             wr_en;
	entry_t           wr_data, cur_entry;

	// Process the held operation when the result register can take it
	assign fire     = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || fire;

	// Input register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Input register payload
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1.operation      <= operation;
			item_s1.target_index   <= target_index;
			item_s1.pattern_number <= pattern_number;
			item_s1.bar_count      <= bar_count;
			item_s1.repeat_count   <= repeat_count;
			item_s1.record_flag    <= record_flag;
		end
	end

	sas_ctrl #(
		.MAX_ENTRIES(MAX_ENTRIES),
		.IDX_W      (IDX_W)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (fire),
		.item     (item_s1),
		.cur_entry(cur_entry),
		.pos_d    (pos_d),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data),
		.result   (res_comb)
	);

	sas_song_table #(
		.DEPTH(MAX_ENTRIES),
		.IDX_W(IDX_W)
	) u_table (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_addr(pos_d),
		.rd_data(cur_entry)
	);

	// Result register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (fire) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	// Result register payload
	always_ff @(posedge clk) begin
		if (fire) begin
			res_s2 <= res_comb;
		end
	end

	assign out_valid        = valid_s2;
	assign status           = res_s2.status;
	assign play_valid       = res_s2.play_valid;
	assign play_pattern     = res_s2.play_pattern;
	assign play_bars        = res_s2.play_bars;
	assign play_record      = res_s2.play_record;
	assign new_entry_index  = res_s2.new_entry_index;
	assign current_position = res_s2.current_position;
	assign entries_in_use   = res_s2.entries_in_use;
	assign is_playing       = res_s2.is_playing;

	// A processed transaction always lands in the result register
	a_fire_lands: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> valid_s2)
		else $error("processed transaction did not reach result register");

	// An empty result register never blocks the input side
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s2 |-> in_ready)
		else $error("input stalled with empty result register");

	// A play command is only issued by a completed operation
	a_play_done: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && res_s2.play_valid) |-> (res_s2.status == STATUS_DONE))
		else $error("play command on ignored operation");

	// Entry count never exceeds the table depth
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (int'(res_s2.entries_in_use) <= MAX_ENTRIES))
		else $error("entry count beyond table depth");

endmodule

// ===== rtl/sas_song_table.sv =====
module sas_song_table #(
	parameter int DEPTH = 64,
	parameter int IDX_W = 6
) (
	input  logic                clk,
	input  logic                wr_en,
	input  logic [IDX_W-1:0]    wr_addr,
	input  sas_pkg::entry_t     wr_data,
	input  logic [IDX_W-1:0]    rd_addr,
	output sas_pkg::entry_t     rd_data
);
	import sas_pkg::*;

	entry_t mem [DEPTH];
	entry_t rd_q;

	// Write one entry; read with write-first bypass so a same-cycle update is seen
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (wr_en && (wr_addr == rd_addr)) begin
			rd_q <= wr_data;
		end else begin
			rd_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_q;

endmodule

// ===== rtl/sas_ctrl.sv =====
module sas_ctrl #(
	parameter int MAX_ENTRIES = 64,
	parameter int IDX_W       = 6
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                fire,
	input  sas_pkg::item_t      item,
	input  sas_pkg::entry_t     cur_entry,
	output logic [IDX_W-1:0]    pos_d,
	output logic                wr_en,
	output logic [IDX_W-1:0]    wr_addr,
	output sas_pkg::entry_t     wr_data,
	output sas_pkg::result_t    result
);
	import sas_pkg::*;

	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
	localparam int CMP_W = (CNT_W > 6) ? CNT_W : 6;

	logic [CNT_W-1:0] total_q, total_n;
	logic [IDX_W-1:0] pos_q, pos_n;
	logic [7:0]       rc_q, rc_n;
	logic             run_q, run_n;
	logic             pause_q, pause_n;

	logic [CNT_W-1:0] pos_ext, pos_inc;
	logic [IDX_W-1:0] pos_fwd, pos_back;
	logic [7:0]       rc_inc;
	logic             idx_ok, full, has_entries, tick_ok, we_n;
	op_t              op;

	// Shared terms of the operation decode
	always_comb begin
		op          = op_t'(item.operation);
		pos_ext     = CNT_W'(pos_q);
		pos_inc     = pos_ext + CNT_W'(1);
		pos_fwd     = (pos_inc >= total_q) ? '0 : IDX_W'(pos_inc);
		pos_back    = (pos_q == '0) ? IDX_W'(total_q - CNT_W'(1)) : pos_q - IDX_W'(1);
		rc_inc      = rc_q + 8'd1;
		has_entries = (total_q != '0);
		idx_ok      = (CMP_W'(item.target_index) < CMP_W'(total_q));
		full        = (total_q >= CNT_W'(MAX_ENTRIES));
		tick_ok     = run_q && !pause_q && has_entries && (pos_ext < total_q);
	end

	// Entry write data: zero bars or repeats are stored as one
	always_comb begin
		wr_data.pattern = item.pattern_number;
		wr_data.bars    = (item.bar_count == 8'd0) ? 8'd1 : item.bar_count;
		wr_data.reps    = (item.repeat_count == 8'd0) ? 8'd1 : item.repeat_count;
		wr_data.record  = item.record_flag;
		wr_addr         = (op == OP_APPEND) ? IDX_W'(total_q) : IDX_W'(item.target_index);
	end

	// Decode the operation into next state and result
	always_comb begin
		total_n = total_q;
		pos_n   = pos_q;
		rc_n    = rc_q;
		run_n   = run_q;
		pause_n = pause_q;
		we_n    = 1'b0;
		result  = '0;
		result.status = STATUS_IGNORED;
		unique case (op)
			OP_TICK: begin
				if (tick_ok) begin
					result.status       = STATUS_DONE;
					result.play_valid   = 1'b1;
					result.play_pattern = cur_entry.pattern;
					result.play_bars    = cur_entry.bars;
					result.play_record  = cur_entry.record;
					if (rc_inc >= cur_entry.reps) begin
						rc_n  = '0;
						pos_n = pos_fwd;
					end else begin
						rc_n = rc_inc;
					end
				end
			end
			OP_START: begin
				if (has_entries) begin
					run_n         = 1'b1;
					pause_n       = 1'b0;
					result.status = STATUS_DONE;
				end
			end
			OP_STOP: begin
				run_n         = 1'b0;
				pause_n       = 1'b0;
				pos_n         = '0;
				rc_n          = '0;
				result.status = STATUS_DONE;
			end
			OP_PAUSE: begin
				if (run_q) begin
					pause_n       = !pause_q;
					result.status = STATUS_DONE;
				end
			end
			OP_NEXT: begin
				if (has_entries) begin
					rc_n          = '0;
					pos_n         = pos_fwd;
					result.status = STATUS_DONE;
				end
			end
			OP_PREV: begin
				if (has_entries) begin
					rc_n          = '0;
					pos_n         = pos_back;
					result.status = STATUS_DONE;
				end
			end
			OP_GOTO: begin
				if (idx_ok) begin
					pos_n         = IDX_W'(item.target_index);
					rc_n          = '0;
					result.status = STATUS_DONE;
				end
			end
			OP_APPEND: begin
				if (!full) begin
					we_n                   = 1'b1;
					total_n                = total_q + CNT_W'(1);
					result.new_entry_index = 6'(total_q);
					result.status          = STATUS_DONE;
				end
			end
			OP_SET: begin
				if (idx_ok) begin
					we_n          = 1'b1;
					result.status = STATUS_DONE;
				end
			end
			OP_CLEAR: begin
				total_n       = '0;
				pos_n         = '0;
				rc_n          = '0;
				result.status = STATUS_DONE;
			end
			default: begin
			end
		endcase
		result.current_position = 6'(pos_n);
		result.entries_in_use   = 7'(total_n);
		result.is_playing       = run_n && !pause_n;
	end

	// Table read address follows the position the next operation will see
	assign pos_d = fire ? pos_n : pos_q;
	assign wr_en = fire && we_n;

	// Advance song state on each processed transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			pos_q   <= '0;
			rc_q    <= '0;
			run_q   <= 1'b0;
			pause_q <= 1'b0;
		end else if (fire) begin
			total_q <= total_n;
			pos_q   <= pos_n;
			rc_q    <= rc_n;
			run_q   <= run_n;
			pause_q <= pause_n;
		end
	end

endmodule

// ===== verif/song_arranger_sequencer_checker.sv =====
`timescale 1ns / 100ps

module song_arranger_sequencer_checker #(
	parameter int MAX_ENTRIES = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_ready,
	input  logic [3:0] operation,
	input  logic [5:0] target_index,
	input  logic [7:0] pattern_number,
	input  logic [7:0] bar_count,
	input  logic [7:0] repeat_count,
	input  logic       record_flag,
	input  logic       out_valid,
	input  logic       out_ready,
	input  logic       status,
	input  logic       play_valid,
	input  logic [7:0] play_pattern,
	input  logic [7:0] play_bars,
	input  logic       play_record,
	input  logic [5:0] new_entry_index,
	input  logic [5:0] current_position,
	input  logic [6:0] entries_in_use,
	input  logic       is_playing,
	output int         mismatch_count,
	output int         pending_count,
	output int         results_checked,
	output int         plays_seen,
	output int         ignored_seen
);
	import sas_pkg::*;

	// Shadow of the arranger state
	entry_t     song [MAX_ENTRIES];
	logic [6:0] song_len;
	logic [5:0] play_pos;
	logic [7:0] repeat_cnt;
	logic       running;
	logic       paused;

	result_t    expected_results [$];

	// Store an entry; zero bars or repeats become one
	function automatic entry_t make_entry(item_t it);
		entry_t e;
		e.pattern = it.pattern_number;
		e.bars    = (it.bar_count == 8'd0) ? 8'd1 : it.bar_count;
		e.reps    = (it.repeat_count == 8'd0) ? 8'd1 : it.repeat_count;
		e.record  = it.record_flag;
		return e;
	endfunction

	// Step forward one entry, wrapping past the last one
	function automatic logic [5:0] wrap_next(logic [5:0] p, logic [6:0] n);
		return (({1'b0, p} + 7'd1) >= n) ? 6'd0 : p + 6'd1;
	endfunction

	// Apply one operation to the shadow state and build its result
	task predict_result(input item_t it, output result_t r);
		entry_t cur;
		r = '0;
		r.status = STATUS_IGNORED;
		case (it.operation)
			OP_TICK: begin
				if (running && !paused && song_len != 7'd0
						&& {1'b0, play_pos} < song_len) begin
					cur = song[play_pos];
					r.status       = STATUS_DONE;
					r.play_valid   = 1'b1;
					r.play_pattern = cur.pattern;
					r.play_bars    = cur.bars;
					r.play_record  = cur.record;
					repeat_cnt = repeat_cnt + 8'd1;
					if (repeat_cnt >= cur.reps) begin
						repeat_cnt = 8'd0;
						play_pos = wrap_next(play_pos, song_len);
					end
				end
			end
			OP_START: begin
				if (song_len != 7'd0) begin
					running = 1'b1;
					paused = 1'b0;
					r.status = STATUS_DONE;
				end
			end
			OP_STOP: begin
				running = 1'b0;
				paused = 1'b0;
				play_pos = 6'd0;
				repeat_cnt = 8'd0;
				r.status = STATUS_DONE;
			end
			OP_PAUSE: begin
				if (running) begin
					paused = !paused;
					r.status = STATUS_DONE;
				end
			end
			OP_NEXT: begin
				if (song_len != 7'd0) begin
					repeat_cnt = 8'd0;
					play_pos = wrap_next(play_pos, song_len);
					r.status = STATUS_DONE;
				end
			end
			OP_PREV: begin
				if (song_len != 7'd0) begin
					repeat_cnt = 8'd0;
					play_pos = (play_pos == 6'd0) ? 6'(song_len - 7'd1) : play_pos - 6'd1;
					r.status = STATUS_DONE;
				end
			end
			OP_GOTO: begin
				if ({1'b0, it.target_index} < song_len) begin
					play_pos = it.target_index;
					repeat_cnt = 8'd0;
					r.status = STATUS_DONE;
				end
			end
			OP_APPEND: begin
				if (song_len < MAX_ENTRIES) begin
					r.new_entry_index = song_len[5:0];
					song[song_len[5:0]] = make_entry(it);
					song_len = song_len + 7'd1;
					r.status = STATUS_DONE;
				end
			end
			OP_SET: begin
				if ({1'b0, it.target_index} < song_len) begin
					song[it.target_index] = make_entry(it);
					r.status = STATUS_DONE;
				end
			end
			OP_CLEAR: begin
				song_len = 7'd0;
				play_pos = 6'd0;
				repeat_cnt = 8'd0;
				r.status = STATUS_DONE;
			end
			default: ;
		endcase
		r.current_position = play_pos;
		r.entries_in_use   = song_len;
		r.is_playing       = running && !paused;
	endtask

	task show_result(input string tag, input result_t r);
		$display("  %s status=%0b play=%0b pat=%0d bars=%0d rec=%0b",
			tag, r.status, r.play_valid, r.play_pattern, r.play_bars, r.play_record);
		$display("  %s new=%0d pos=%0d count=%0d playing=%0b",
			tag, r.new_entry_index, r.current_position, r.entries_in_use, r.is_playing);
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		item_t   taken;
		result_t got;
		result_t want;
		if (!arst_n) begin
			song_len = 7'd0;
			play_pos = 6'd0;
			repeat_cnt = 8'd0;
			running = 1'b0;
			paused = 1'b0;
			expected_results.delete();
			mismatch_count = 0;
			pending_count = 0;
			results_checked = 0;
			plays_seen = 0;
			ignored_seen = 0;
		end else begin
			// Compare a result transaction with the oldest prediction
			if (out_valid && out_ready) begin
				got = {status, play_valid, play_pattern, play_bars, play_record,
					new_entry_index, current_position, entries_in_use, is_playing};
				results_checked++;
				if (got.play_valid === 1'b1)
					plays_seen++;
				if (got.status === STATUS_IGNORED)
					ignored_seen++;
				if (expected_results.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("%0t: result transaction with no prediction waiting", $time);
				end else begin
					want = expected_results.pop_front();
					if (got !== want) begin
						mismatch_count++;
						if (mismatch_count <= 10) begin
							$display("%0t: mismatch on result %0d", $time, results_checked);
							show_result("expected", want);
							show_result("actual  ", got);
						end
					end
				end
			end
			// Predict the result of an accepted operation
			if (in_valid && in_ready) begin
				taken = {operation, target_index, pattern_number, bar_count, repeat_count,
					record_flag};
				predict_result(taken, want);
				expected_results.push_back(want);
			end
			pending_count = expected_results.size();
		end
	end

endmodule

// ===== verif/tb_song_arranger_sequencer.sv =====
`timescale 1ns / 100ps

module tb_song_arranger_sequencer;
	import sas_pkg::*;

	localparam int         MAX_ENTRIES  = 64;
	localparam int         TOTAL_ITEMS  = 1800;
	localparam int         CYCLE_LIMIT  = 400000;
	localparam int         LONG_HOLD    = 400;
	localparam int         DRAIN_CYCLES = 8;
	localparam logic [3:0] OP_UNUSED_LO = 4'd10;
	localparam logic [3:0] OP_UNUSED_HI = 4'd15;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [3:0] operation;
	logic [5:0] target_index;
	logic [7:0] pattern_number;
	logic [7:0] bar_count;
	logic [7:0] repeat_count;
	logic       record_flag;
	logic       out_valid;
	logic       out_ready;
	logic       status;
	logic       play_valid;
	logic [7:0] play_pattern;
	logic [7:0] play_bars;
	logic       play_record;
	logic [5:0] new_entry_index;
	logic [5:0] current_position;
	logic [6:0] entries_in_use;
	logic       is_playing;

	int mismatch_count;
	int pending_count;
	int results_checked;
	int plays_seen;
	int ignored_seen;

	int items_sent = 0;
	int cycle_count = 0;
	bit sender_burst = 1'b0;
	bit receiver_burst = 1'b0;

	song_arranger_sequencer #(.MAX_ENTRIES(MAX_ENTRIES)) u_top (.*);

	song_arranger_sequencer_checker #(.MAX_ENTRIES(MAX_ENTRIES)) u_checker (.*);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results pending", cycle_count, pending_count);
			$display("Test completed with failures");
			$finish;
		end
	end

	// Mostly no gap, some short ones, a few long ones
	function automatic int pick_gap(bit burst);
		int r;
		if (burst)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [7:0] pick_byte(int small_max);
		return ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
			: 8'($urandom_range(0, small_max));
	endfunction

	function automatic logic [5:0] pick_index();
		return ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
			: 6'($urandom_range(0, 9));
	endfunction

	// Offer one operation and hold it until the transaction completes
	task send_operation(input logic [3:0] op, input logic [5:0] idx, input logic [7:0] pat,
			input logic [7:0] bars, input logic [7:0] reps, input logic rec);
		int gap;
		gap = pick_gap(sender_burst);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid       <= 1'b1;
		operation      <= op;
		target_index   <= idx;
		pattern_number <= pat;
		bar_count      <= bars;
		repeat_count   <= reps;
		record_flag    <= rec;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		items_sent++;
	endtask

	// Operation with all other fields random
	task send_noisy(input logic [3:0] op);
		send_operation(op, 6'($urandom_range(0, 63)), 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
			1'($urandom_range(0, 1)));
	endtask

	// Entry payload with mostly short bars and repeats
	task send_entry(input logic [3:0] op, input logic [5:0] idx);
		send_operation(op, idx, 8'($urandom_range(0, 255)), pick_byte(4), pick_byte(3),
			1'($urandom_range(0, 1)));
	endtask

	task random_operation();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			send_noisy(OP_TICK);
		else if (r < 60)
			send_noisy(OP_PAUSE);
		else if (r < 64)
			send_noisy(OP_NEXT);
		else if (r < 68)
			send_noisy(OP_PREV);
		else if (r < 74)
			send_entry(OP_GOTO, pick_index());
		else if (r < 80)
			send_entry(OP_SET, pick_index());
		else if (r < 83)
			send_entry(OP_APPEND, pick_index());
		else if (r < 86)
			send_noisy(OP_START);
		else if (r < 88)
			send_noisy(OP_STOP);
		else if (r < 89)
			send_noisy(OP_CLEAR);
		else if (r < 93)
			send_noisy(4'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI)));
		else
			send_noisy(4'($urandom_range(0, 15)));
	endtask

	// Optionally clear, build a song, usually start it, then play and edit it
	task play_scene();
		int song_size;
		sender_burst = ($urandom_range(0, 4) == 0);
		if ($urandom_range(0, 2) != 0)
			send_noisy(OP_CLEAR);
		if ($urandom_range(0, 9) == 0)
			song_size = MAX_ENTRIES + $urandom_range(1, 2);
		else
			song_size = $urandom_range(1, 8);
		repeat (song_size)
			send_entry(OP_APPEND, 6'($urandom_range(0, 63)));
		if ($urandom_range(0, 7) != 0)
			send_noisy(OP_START);
		repeat ($urandom_range(10, 60))
			random_operation();
	endtask

	// Drive the result side, with one long hold-off to back up the block
	initial begin : drive_ready
		int loops;
		int gap;
		loops = 0;
		out_ready = 1'b0;
		wait (arst_n);
		forever begin
			loops++;
			receiver_burst = ($urandom_range(0, 5) == 0);
			if (loops == 60) begin
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end
			out_ready <= 1'b1;
			repeat ($urandom_range(1, receiver_burst ? 200 : 12)) @(posedge clk);
			gap = pick_gap(receiver_burst);
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		operation = OP_TICK;
		target_index = 6'd0;
		pattern_number = 8'd0;
		bar_count = 8'd0;
		repeat_count = 8'd0;
		record_flag = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Empty song: everything but stop, clear and append is ignored
		send_operation(OP_TICK, 6'd0, 8'd0, 8'd0, 8'd0, 1'b0);
		send_operation(OP_START, 6'd0, 8'd0, 8'd0, 8'd0, 1'b0);
		send_operation(OP_PAUSE, 6'd0, 8'd0, 8'd0, 8'd0, 1'b0);
		send_operation(OP_NEXT, 6'd0, 8'd0, 8'd0, 8'd0, 1'b0);
		send_operation(OP_PREV, 6'd0, 8'd0, 8'd0, 8'd0, 1'b0);
		send_operation(OP_GOTO, 6'd0, 8'd0, 8'd0, 8'd0, 1'b0);
		send_operation(OP_SET, 6'd0, 8'd1, 8'd1, 8'd1, 1'b1);
		send_operation(OP_UNUSED_HI, 6'd63, 8'd255, 8'd255, 8'd255, 1'b1);
		send_operation(OP_UNUSED_LO, 6'd0, 8'd0, 8'd0, 8'd0, 1'b0);

		// Field extremes, zero bars and repeats stored as one
		send_operation(OP_APPEND, 6'd63, 8'd0, 8'd0, 8'd0, 1'b0);
		send_operation(OP_APPEND, 6'd0, 8'd255, 8'd255, 8'd255, 1'b1);
		send_operation(OP_APPEND, 6'd21, 8'hA5, 8'd2, 8'd3, 1'b0);
		send_operation(OP_TICK, 6'd0, 8'd0, 8'd0, 8'd0, 1'b0);

		// Play, pause, resume by start
		send_operation(OP_START, 6'd0, 8'd0, 8'd0, 8'd0, 1'b0);
		send_operation(OP_TICK, 6'd0, 8'd0, 8'd0, 8'd0, 1'b0);
		send_operation(OP_TICK, 6'd0, 8'd0, 8'd0, 8'd0, 1'b0);
		send_operation(OP_PAUSE, 6'd0, 8'd0, 8'd0, 8'd0, 1'b0);
		send_operation(OP_TICK, 6'd0, 8'd0, 8'd0, 8'd0, 1'b0);
		send_operation(OP_START, 6'd0, 8'd0, 8'd0, 8'd0, 1'b0);

		// Lower the repeats of the entry in play, then navigate with wrap
		send_operation(OP_SET, 6'd1, 8'h5A, 8'd0, 8'd1, 1'b1);
		send_operation(OP_TICK, 6'd0, 8'd0, 8'd0, 8'd0, 1'b0);
		send_operation(OP_NEXT, 6'd0, 8'd0, 8'd0, 8'd0, 1'b0);
		send_operation(OP_PREV, 6'd0, 8'd0, 8'd0, 8'd0, 1'b0);
		send_operation(OP_GOTO, 6'd63, 8'd0, 8'd0, 8'd0, 1'b0);
		send_operation(OP_GOTO, 6'd1, 8'd0, 8'd0, 8'd0, 1'b0);
		send_operation(OP_STOP, 6'd0, 8'd0, 8'd0, 8'd0, 1'b0);

		// Clear while running keeps the flags
		send_operation(OP_START, 6'd0, 8'd0, 8'd0, 8'd0, 1'b0);
		send_operation(OP_CLEAR, 6'd0, 8'd0, 8'd0, 8'd0, 1'b0);
		send_operation(OP_TICK, 6'd0, 8'd0, 8'd0, 8'd0, 1'b0);

		while (items_sent < TOTAL_ITEMS)
			play_scene();
		in_valid <= 1'b0;

		// Drain outstanding results, then watch for strays
		@(negedge clk);
		while (pending_count != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d operations; checked %0d results, %0d play commands, %0d ignored",
			items_sent, results_checked, plays_seen, ignored_seen);
		$display("Mismatches: %0d", mismatch_count);
		if (mismatch_count == 0 && pending_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/sas_pkg.sv
rtl/sas_song_table.sv
rtl/sas_ctrl.sv
rtl/song_arranger_sequencer.sv
verif/song_arranger_sequencer_checker.sv
verif/tb_song_arranger_sequencer.sv
